FILE: hw/rtl/hdg_pkg.sv
// shared types, widths and the arctangent table for the heading pipeline
`timescale 1ns / 1ps

package hdg_pkg;

    // number of cordic iterations, limited to the length of the angle table
    localparam int ANGLE_ITERATIONS = 16;
    localparam int TABLE_LEN        = 24;
    localparam int ITER             = (ANGLE_ITERATIONS > TABLE_LEN) ? TABLE_LEN
                                                                     : ANGLE_ITERATIONS;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int DECL_W   = 15;
    localparam int HEAD_W   = 15;

    // internal widths: vector in samples * 256 plus cordic growth, angle in 1/16384 degree
    localparam int FRAC_W = 8;
    localparam int XW     = 27;
    localparam int ZW     = 24;
    localparam int SUM_W  = 25;
    localparam int HW     = SUM_W - FRAC_W;

    // distance from the accepting edge to the edge that takes the result: the
    // item passes the front register, the cordic stages, the rounding register
    // and the wrap register, and done is taken at the edge that ends its cycle
    localparam int LATENCY = ITER + 3;

    typedef logic signed [XW-1:0]     vec_coord_t;
    typedef logic signed [ZW-1:0]     angle_t;
    typedef logic signed [DECL_W-1:0] decl_t;
    typedef logic signed [HW-1:0]     coarse_t;

    // one item in flight through the cordic stages
    typedef struct packed {
        vec_coord_t x;
        vec_coord_t y;
        angle_t     z;
        logic       zero;
    } hdg_vec_t;

    localparam angle_t QUARTER_FINE = angle_t'(1474560);

    localparam decl_t DECL_MAX = decl_t'(11520);
    localparam decl_t DECL_MIN = decl_t'(-11520);

    localparam coarse_t FULL_TURN     = coarse_t'(23040);
    localparam coarse_t NEG_FULL_TURN = coarse_t'(-23040);
    localparam coarse_t TWO_TURNS     = coarse_t'(46080);

    // round(atan(2^-i) in degrees * 16384)
    localparam angle_t ATAN_FINE [TABLE_LEN] = '{
        angle_t'(737280), angle_t'(435242), angle_t'(229970), angle_t'(116736),
        angle_t'(58595),  angle_t'(29326),  angle_t'(14667),  angle_t'(7334),
        angle_t'(3667),   angle_t'(1833),   angle_t'(917),    angle_t'(458),
        angle_t'(229),    angle_t'(115),    angle_t'(57),     angle_t'(29),
        angle_t'(14),     angle_t'(7),      angle_t'(4),      angle_t'(2),
        angle_t'(1),      angle_t'(0),      angle_t'(0),      angle_t'(0)
    };

endpackage

FILE: hw/rtl/magnetometer_heading.sv
// top level of the compass heading pipeline
`timescale 1ns / 1ps

// compass heading from one raw x/y magnetometer sample
//
// input channel: drive mag_x, mag_y and pulse start; an item is taken at
// every rising edge with start high and busy low. busy is always low, so
// a new item may enter in every cycle.
// result channel: done is high for exactly one cycle with heading valid
// in the same cycle; the receiver has to take it then.
// heading is atan2(mag_y, mag_x) plus declination, in 1/64 degree,
// wrapped into 0 .. 23039. a zero vector gives the wrapped declination.
// path: an accepted item passes one input register, one register per
// cordic iteration, one rounding register and one wrap register before
// done rises.
// throughput: one item per cycle, set by the fully unrolled cordic.
// declination: written through cfg_we / cfg_data, saturated to +-180
// degrees on write; write it only while no item is in flight.
// reset: rst_n clears all valid bits and sets declination to zero; items
// in flight are dropped.

module magnetometer_heading
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [hdg_pkg::SAMPLE_W-1:0]   mag_x,
    input  logic signed [hdg_pkg::SAMPLE_W-1:0]   mag_y,
    input  logic                                  cfg_we,
    input  logic signed [hdg_pkg::DECL_W-1:0]     cfg_data,
    output logic                                  done,
    output logic [hdg_pkg::HEAD_W-1:0]            heading
);

    hdg_pkg::decl_t    decl_reg;
    hdg_pkg::decl_t    decl_next;
    logic              front_valid;
    hdg_pkg::hdg_vec_t front_vec;
    logic              cordic_valid;
    hdg_pkg::hdg_vec_t cordic_vec;

    // the pipeline never stalls
    assign busy = 1'b0;

    // saturate the declination on write
    always_comb
    begin
        if (cfg_data > hdg_pkg::DECL_MAX)
        begin
            decl_next = hdg_pkg::DECL_MAX;
        end
        else if (cfg_data < hdg_pkg::DECL_MIN)
        begin
            decl_next = hdg_pkg::DECL_MIN;
        end
        else
        begin
            decl_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg <= '0;
        end
        else if (cfg_we)
        begin
            decl_reg <= decl_next;
        end
    end

    // scaling and pre-rotation into the right half-plane
    hdg_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .mag_x     (mag_x),
        .mag_y     (mag_y),
        .out_valid (front_valid),
        .out_vec   (front_vec)
    );

    // angle accumulation, one iteration per stage
    hdg_cordic u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_vec    (front_vec),
        .out_valid (cordic_valid),
        .out_vec   (cordic_vec)
    );

    // declination, rounding to 1/64 degree and wrap
    hdg_wrap u_wrap
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (cordic_valid),
        .in_vec      (cordic_vec),
        .declination (decl_reg),
        .out_valid   (done),
        .heading     (heading)
    );

endmodule

FILE: hw/rtl/hdg_front.sv
// input register: scaling, left half-plane pre-rotation and zero detect
`timescale 1ns / 1ps

module hdg_front
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic signed [hdg_pkg::SAMPLE_W-1:0]   mag_x,
    input  logic signed [hdg_pkg::SAMPLE_W-1:0]   mag_y,
    output logic                                  out_valid,
    output hdg_pkg::hdg_vec_t                     out_vec
);

    hdg_pkg::vec_coord_t xs;
    hdg_pkg::vec_coord_t ys;
    hdg_pkg::hdg_vec_t   vec_next;
    hdg_pkg::hdg_vec_t   vec_reg;
    logic                valid_reg;

    always_comb
    begin
        xs = hdg_pkg::vec_coord_t'(mag_x) <<< hdg_pkg::FRAC_W;
        ys = hdg_pkg::vec_coord_t'(mag_y) <<< hdg_pkg::FRAC_W;
        vec_next.zero = (mag_x == '0) && (mag_y == '0);
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                // rotate clockwise by 90 degrees
                vec_next.x = ys;
                vec_next.y = -xs;
                vec_next.z = hdg_pkg::QUARTER_FINE;
            end
            else
            begin
                // rotate counter-clockwise by 90 degrees
                vec_next.x = -ys;
                vec_next.y = xs;
                vec_next.z = -hdg_pkg::QUARTER_FINE;
            end
        end
        else
        begin
            vec_next.x = xs;
            vec_next.y = ys;
            vec_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

FILE: hw/rtl/hdg_cordic.sv
// vectoring cordic, one registered stage per iteration
`timescale 1ns / 1ps

module hdg_cordic
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  hdg_pkg::hdg_vec_t in_vec,
    output logic              out_valid,
    output hdg_pkg::hdg_vec_t out_vec
);

    hdg_pkg::hdg_vec_t stage_reg   [hdg_pkg::ITER];
    logic              valid_reg   [hdg_pkg::ITER];

    for (genvar i = 0; i < hdg_pkg::ITER; i++)
    begin : g_stage
        hdg_pkg::hdg_vec_t prev;
        hdg_pkg::hdg_vec_t stage_next;
        logic              prev_valid;

        if (i == 0)
        begin : g_first
            assign prev       = in_vec;
            assign prev_valid = in_valid;
        end
        else
        begin : g_rest
            assign prev       = stage_reg[i-1];
            assign prev_valid = valid_reg[i-1];
        end

        always_comb
        begin
            stage_next.zero = prev.zero;
            if (prev.y >= 0)
            begin
                stage_next.x = prev.x + (prev.y >>> i);
                stage_next.y = prev.y - (prev.x >>> i);
                stage_next.z = prev.z + hdg_pkg::ATAN_FINE[i];
            end
            else
            begin
                stage_next.x = prev.x - (prev.y >>> i);
                stage_next.y = prev.y + (prev.x >>> i);
                stage_next.z = prev.z - hdg_pkg::ATAN_FINE[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            stage_reg[i] <= stage_next;
        end
    end

    assign out_valid = valid_reg[hdg_pkg::ITER-1];
    assign out_vec   = stage_reg[hdg_pkg::ITER-1];

endmodule

FILE: hw/rtl/hdg_wrap.sv
// declination add with rounding, then wrap into one full turn
`timescale 1ns / 1ps

module hdg_wrap
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  hdg_pkg::hdg_vec_t                   in_vec,
    input  hdg_pkg::decl_t                      declination,
    output logic                                out_valid,
    output logic [hdg_pkg::HEAD_W-1:0]          heading
);

    logic signed [hdg_pkg::SUM_W-1:0] angle_ext;
    logic signed [hdg_pkg::SUM_W-1:0] decl_ext;
    logic signed [hdg_pkg::SUM_W-1:0] sum;
    hdg_pkg::coarse_t                 coarse_next;
    hdg_pkg::coarse_t                 coarse_reg;
    hdg_pkg::coarse_t                 wrapped;
    logic                             round_valid_reg;
    logic                             out_valid_reg;
    logic [hdg_pkg::HEAD_W-1:0]       heading_reg;

    always_comb
    begin
        angle_ext   = in_vec.zero ? '0 : hdg_pkg::SUM_W'(in_vec.z);
        decl_ext    = hdg_pkg::SUM_W'(declination) <<< hdg_pkg::FRAC_W;
        sum         = angle_ext + decl_ext + hdg_pkg::SUM_W'(128);
        // floor of sum / 256 is the upper bits
        coarse_next = sum[hdg_pkg::SUM_W-1:hdg_pkg::FRAC_W];
    end

    always_comb
    begin
        if (coarse_reg < hdg_pkg::NEG_FULL_TURN)
        begin
            wrapped = coarse_reg + hdg_pkg::TWO_TURNS;
        end
        else if (coarse_reg < 0)
        begin
            wrapped = coarse_reg + hdg_pkg::FULL_TURN;
        end
        else if (coarse_reg >= hdg_pkg::FULL_TURN)
        begin
            wrapped = coarse_reg - hdg_pkg::FULL_TURN;
        end
        else
        begin
            wrapped = coarse_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            round_valid_reg <= in_valid;
            out_valid_reg   <= round_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        coarse_reg  <= coarse_next;
        heading_reg <= wrapped[hdg_pkg::HEAD_W-1:0];
    end

    assign out_valid = out_valid_reg;
    assign heading   = heading_reg;

endmodule

FILE: hw/rtl/hdg_checker.sv
// port-level checks for the heading pipeline and their binding
`timescale 1ns / 1ps

module hdg_checker
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic                                  done,
    input logic [hdg_pkg::HEAD_W-1:0]            heading
);

    // heading inside one full turn whenever done is high
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (heading < hdg_pkg::HEAD_W'(23040)))
        else $error("heading out of range");

    // every accepted item gives a result after the fixed latency
    a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(hdg_pkg::LATENCY) done)
        else $error("accepted item gave no result");

    // no result without an item accepted at the fixed distance before
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, hdg_pkg::LATENCY))
        else $error("result without accepted item");

    // the pipeline never holds off input
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind magnetometer_heading hdg_checker u_hdg_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .heading (heading)
);
